// File: rtl/core/auto_cross_correlation_unit_assert.svh
// Assertion macros for the correlation unit.
// Used inside module bodies; expects i_clk and i_rst_n in scope.
`ifndef AUTO_CROSS_CORRELATION_UNIT_ASSERT_SVH
`define AUTO_CROSS_CORRELATION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ACCU_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ACCU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ACCU_ASSERT(label, ante, cons)
`define ACCU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/accu_pkg.sv
// Shared types and constants of the correlation unit.
// No dependencies.
package accu_pkg;

    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RECORD_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SELF_LAGS     = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CROSS_LAGS    = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_INV_SCALE     = 2'd3;

    localparam logic KIND_AUTO  = 1'b0;
    localparam logic KIND_CROSS = 1'b1;

    localparam int VALUE_BITS = 48;
    localparam logic [VALUE_BITS-1:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [VALUE_BITS-1:0] SAT_NEG = 48'h8000_0000_0000;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_MAC   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_SAT   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

endpackage

// File: rtl/core/accu_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module accu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end
endmodule

// File: rtl/core/auto_cross_correlation_unit.sv
// Two-channel auto/cross correlation unit: top level with sequencer and datapath.
// Depends on accu_pkg, accu_ram and auto_cross_correlation_unit_assert.svh.
//
// Sample pairs stream in one per cycle until record_length pairs are stored. The block
// then drops s_tready and emits (self_lags+1) autocorrelation results followed by
// (cross_lags+1) cross-correlation results, tlast on the final one. Each result runs one
// multiply-accumulate pass over the record, count = record_length - max lag terms at one
// term per cycle through a two-read-port sample memory, then for each of its two values a
// restoring divider (one quotient bit per cycle, 2*SAMPLE_BITS+clog2(RECORD_MAX+1)+1 bits)
// and a shift-add scaler (one inv_scale bit per cycle, 32 bits). A result whose count is
// not positive is flagged invalid and is sent with zero values.
`include "auto_cross_correlation_unit_assert.svh"
module auto_cross_correlation_unit
    import accu_pkg::*;
#(
    parameter int RECORD_MAX  = 4096,
    parameter int LAG_MAX     = 31,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // tdata: gate_sample[15:0], drain_sample[31:16]
    input  logic [31:0]              i_s_tdata,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // tdata: lag[4:0], value_a[52:5], value_b[100:53], zero fill [103:101]
    output logic [103:0]             o_m_tdata,
    // tuser: kind[0], invalid[1]
    output logic [1:0]               o_m_tuser,
    output logic                     o_m_tlast,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [31:0]              i_cfg_wdata
);
    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = $clog2(RECORD_MAX);
    localparam int LW  = $clog2(RECORD_MAX + 1);
    localparam int SW  = 2 * SB + LW + 1;
    localparam int PW  = SW + 32;
    localparam int RXW = (SW + 16 > 48) ? SW + 16 : 48;
    localparam int ITN = (SW > 32) ? SW : 32;
    localparam int ITW = $clog2(ITN + 1);

    // configuration registers
    logic [12:0] r_record_length;
    logic [4:0]  r_self_lags;
    logic [4:0]  r_cross_lags;
    logic [31:0] r_inv_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_length <= 13'd4096;
            r_self_lags     <= 5'd31;
            r_cross_lags    <= 5'd31;
            r_inv_scale     <= 32'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_RECORD_LENGTH: r_record_length <= i_cfg_wdata[12:0];
                CFG_SELF_LAGS:     r_self_lags     <= i_cfg_wdata[4:0];
                CFG_CROSS_LAGS:    r_cross_lags    <= i_cfg_wdata[4:0];
                CFG_INV_SCALE:     r_inv_scale     <= i_cfg_wdata;
                default:           r_inv_scale     <= r_inv_scale;
            endcase
        end
    end

    // clamped length and lags
    logic [LW-1:0] w_len;
    logic [4:0]    w_sl;
    logic [4:0]    w_cl;
    always_comb begin
        if (r_record_length == 13'd0) begin
            w_len = LW'(1);
        end else if (32'(r_record_length) > 32'(RECORD_MAX)) begin
            w_len = LW'(RECORD_MAX);
        end else begin
            w_len = LW'(r_record_length);
        end
        w_sl = (32'(r_self_lags) > 32'(LAG_MAX)) ? 5'(LAG_MAX) : r_self_lags;
        w_cl = (32'(r_cross_lags) > 32'(LAG_MAX)) ? 5'(LAG_MAX) : r_cross_lags;
    end

    // input samples
    logic [SB-1:0] w_gate_in;
    logic [SB-1:0] w_drain_in;
    if (SB <= 16) begin : g_narrow
        assign w_gate_in  = i_s_tdata[SB-1:0];
        assign w_drain_in = i_s_tdata[16+SB-1:16];
    end else begin : g_wide
        assign w_gate_in  = {{(SB-16){1'b0}}, i_s_tdata[15:0]};
        assign w_drain_in = {{(SB-16){1'b0}}, i_s_tdata[31:16]};
    end

    t_state          r_state;
    logic [LW-1:0]   r_load_cnt;
    logic            r_kind;
    logic [4:0]      r_lag;
    logic [LW-1:0]   r_count;
    logic [LW-1:0]   r_t;
    logic            r_rd_vld;
    logic            r_pr_vld;
    logic signed [2*SB-1:0] r_pr_a;
    logic signed [2*SB-1:0] r_pr_b;
    logic signed [SW-1:0]   r_acc_a;
    logic signed [SW-1:0]   r_acc_b;
    logic            r_sel;
    logic            r_neg;
    logic [SW-1:0]   r_quo;
    logic [LW-1:0]   r_rem;
    logic [PW-1:0]   r_mcand;
    logic [31:0]     r_mplier;
    logic [PW-1:0]   r_prod;
    logic [ITW-1:0]  r_it;
    logic [47:0]     r_val_a;
    logic [47:0]     r_val_b;
    logic            r_invalid;

    logic w_accept;
    logic w_fire;
    logic w_last;
    logic [4:0] w_maxlag;
    assign o_s_tready = (r_state == S_LOAD);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_fire     = ({1'b0, r_load_cnt} + (LW+1)'(1)) >= {1'b0, w_len};
    assign w_maxlag   = r_kind ? w_cl : w_sl;
    assign w_last     = r_kind && (r_lag == w_cl);

    // sample memories
    logic [AW-1:0] w_raddr0;
    logic [AW-1:0] w_raddr1;
    logic [LW-1:0] w_t_lag;
    logic [SB-1:0] w_g0, w_g1, w_d0, w_d1;
    logic          w_we;
    assign w_t_lag  = r_t + LW'(r_lag);
    assign w_raddr0 = r_t[AW-1:0];
    assign w_raddr1 = w_t_lag[AW-1:0];
    assign w_we     = w_accept && (32'(r_load_cnt) < 32'(RECORD_MAX));

    accu_ram #(.WIDTH(SB), .DEPTH(RECORD_MAX)) u_gate_ram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (r_load_cnt[AW-1:0]),
        .i_wdata  (w_gate_in),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_g0),
        .o_rdata1 (w_g1)
    );

    accu_ram #(.WIDTH(SB), .DEPTH(RECORD_MAX)) u_drain_ram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (r_load_cnt[AW-1:0]),
        .i_wdata  (w_drain_in),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_d0),
        .o_rdata1 (w_d1)
    );

    // products: auto pairs channel with itself, cross pairs each with the other later
    logic signed [2*SB-1:0] w_pa;
    logic signed [2*SB-1:0] w_pb;
    logic                   w_issue;
    logic signed [LW+1:0]   w_count_s;
    assign w_pa = $signed(w_g0) * $signed(r_kind ? w_d1 : w_g1);
    assign w_pb = $signed(w_d0) * $signed(r_kind ? w_g1 : w_d1);
    assign w_issue = (r_state == S_MAC) && (r_t < r_count);
    assign w_count_s = $signed({2'b0, w_len}) - $signed((LW+2)'(w_maxlag));

    // restoring divider step
    logic [LW:0]   w_rem_sh;
    logic          w_qbit;
    logic [LW-1:0] w_rem_next;
    logic [SW-1:0] w_quo_next;
    always_comb begin
        w_rem_sh   = {r_rem, r_quo[SW-1]};
        w_qbit     = w_rem_sh >= {1'b0, r_count};
        w_rem_next = w_qbit ? LW'(w_rem_sh - {1'b0, r_count}) : w_rem_sh[LW-1:0];
        w_quo_next = {r_quo[SW-2:0], w_qbit};
    end

    // saturation of the scaled magnitude
    logic [RXW-1:0] w_r;
    logic [RXW-1:0] w_lim;
    logic [RXW-1:0] w_rc;
    logic [47:0]    w_sat;
    always_comb begin
        w_r   = RXW'(r_prod[PW-1:16]);
        w_lim = r_neg ? RXW'(SAT_NEG) : RXW'(SAT_POS);
        w_rc  = (w_r > w_lim) ? w_lim : w_r;
        w_sat = r_neg ? (48'd0 - w_rc[47:0]) : w_rc[47:0];
    end

    logic [SW-1:0] w_mag_a;
    logic [SW-1:0] w_mag_b;
    assign w_mag_a = r_acc_a[SW-1] ? SW'(-r_acc_a) : SW'(r_acc_a);
    assign w_mag_b = r_acc_b[SW-1] ? SW'(-r_acc_b) : SW'(r_acc_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_kind     <= KIND_AUTO;
            r_lag      <= '0;
            r_rd_vld   <= 1'b0;
            r_pr_vld   <= 1'b0;
            r_sel      <= 1'b0;
            r_it       <= '0;
            r_t        <= '0;
            r_count    <= '0;
            r_invalid  <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
            r_pr_vld <= r_rd_vld;
            r_pr_a   <= w_pa;
            r_pr_b   <= w_pb;
            case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_fire) begin
                            r_load_cnt <= '0;
                            r_kind     <= KIND_AUTO;
                            r_lag      <= '0;
                            r_state    <= S_SETUP;
                        end else begin
                            r_load_cnt <= r_load_cnt + LW'(1);
                        end
                    end
                end
                S_SETUP: begin
                    r_t     <= '0;
                    r_acc_a <= '0;
                    r_acc_b <= '0;
                    r_sel   <= 1'b0;
                    if (w_count_s <= 0) begin
                        r_invalid <= 1'b1;
                        r_val_a   <= '0;
                        r_val_b   <= '0;
                        r_state   <= S_OUT;
                    end else begin
                        r_invalid <= 1'b0;
                        r_count   <= LW'(w_count_s);
                        r_state   <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (w_issue) begin
                        r_t <= r_t + LW'(1);
                    end
                    if (r_pr_vld) begin
                        r_acc_a <= r_acc_a + SW'(r_pr_a);
                        r_acc_b <= r_acc_b + SW'(r_pr_b);
                    end
                    if (!w_issue && !r_rd_vld && !r_pr_vld) begin
                        r_quo   <= w_mag_a;
                        r_neg   <= r_acc_a[SW-1];
                        r_rem   <= '0;
                        r_it    <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_rem_next;
                    r_quo <= w_quo_next;
                    if (r_it == ITW'(SW - 1)) begin
                        r_mcand  <= PW'(w_quo_next);
                        r_mplier <= r_inv_scale;
                        r_prod   <= '0;
                        r_it     <= '0;
                        r_state  <= S_MUL;
                    end else begin
                        r_it <= r_it + ITW'(1);
                    end
                end
                S_MUL: begin
                    if (r_mplier[0]) begin
                        r_prod <= r_prod + r_mcand;
                    end
                    r_mcand  <= {r_mcand[PW-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[31:1]};
                    r_it     <= r_it + ITW'(1);
                    if (r_it == ITW'(31)) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    r_it <= '0;
                    if (!r_sel) begin
                        r_val_a <= w_sat;
                        r_sel   <= 1'b1;
                        r_quo   <= w_mag_b;
                        r_neg   <= r_acc_b[SW-1];
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_val_b <= w_sat;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold the result until the transfer completes
                    if (i_m_tready) begin
                        if (w_last) begin
                            r_state <= S_LOAD;
                        end else if (r_lag == w_maxlag) begin
                            r_kind  <= KIND_CROSS;
                            r_lag   <= '0;
                            r_state <= S_SETUP;
                        end else begin
                            r_lag   <= r_lag + 5'd1;
                            r_state <= S_SETUP;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {3'b000, r_val_b, r_val_a, r_lag};
    assign o_m_tuser  = {r_invalid, r_kind};
    assign o_m_tlast  = w_last;

    `ACCU_ASSERT(a_no_overlap, o_s_tready, !o_m_tvalid)
    `ACCU_ASSERT(a_invalid_zero, o_m_tvalid && o_m_tuser[1], o_m_tdata[100:5] == 96'd0)
    `ACCU_ASSERT(a_mac_bound, r_state == S_MAC, r_t <= r_count)
    `ACCU_ASSERT_NEXT(a_last_reload, o_m_tvalid && i_m_tready && o_m_tlast, o_s_tready)
endmodule
